/* hdl/alt_pkg.sv */
// shared types and constants for the array list table
package alt_pkg;

  localparam int DEF_CAPACITY = 8;
  localparam int MAX_CAPACITY = 64;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int ROT_W  = 16;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 7;

  typedef enum logic [1:0] {
    M_INSERT = 2'd0,
    M_DELETE = 2'd1,
    M_SEARCH = 2'd2,
    M_ROTATE = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_WALK = 2'd2
  } state_e;

endpackage

/* hdl/alt_divrem.sv */
// bit-serial remainder unit: rotate count modulo the entry count
module alt_divrem import alt_pkg::*; #(
  parameter int CW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [ROT_W-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [CW-1:0] rem_o
);

  localparam int BW  = $clog2(ROT_W);
  localparam int CW1 = CW + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic [ROT_W-1:0] dvd_q, dvd_d;
  logic [CW-1:0]    dvs_q, dvs_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW:0]      trial;

  // one restoring step per cycle, msb first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[ROT_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BW'(ROT_W - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[ROT_W-2:0], 1'b0};
      if (trial >= CW1'(dvs_q)) begin
        rem_d = CW'(trial - CW1'(dvs_q));
      end else begin
        rem_d = trial[CW-1:0];
      end
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/array_list_table.sv */
// array list table: ordered list of signed words kept in two ping-pong memories
//
// Usage: drive mode_i, position_i, entry_value_i and rotate_count_i and raise
// start_i; the request is taken at a clock edge where start_i is high and
// busy_o is low. Exactly one result word follows: done_o is high for one cycle
// with status_o, removed_value_o, found_position_o and item_count_o valid.
// The receiver cannot stall; results must be taken in that cycle.
// A rejected request (full, empty, bad position) is answered without a walk.
// Insert and delete walk the entries from the position to the end of the
// list, a search walks the whole list, and a rotate walks the whole list
// after the serial modulo of the rotate count. All walks run one list
// entry per cycle through the single read port of the live memory.
// Rotation copies the list into the other memory and flips the live bank.
// busy_o is low in the cycle done_o is high, so requests may follow at once.
// Reset empties the list; memory contents are not cleared, as only entries
// below the count are ever read.
module array_list_table import alt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               mode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic [ROT_W-1:0]         rotate_count_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic [OUT_W-1:0]         found_position_o,
  output logic [OUT_W-1:0]         item_count_o
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CW1 = CW + 1;
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // list memories, one live and one used as rotate target
  logic signed [DATA_W-1:0] bank0 [CAPACITY];
  logic signed [DATA_W-1:0] bank1 [CAPACITY];
  logic signed [DATA_W-1:0] rdata0_q, rdata1_q, rdata;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en, wr_bank;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  state_e                   state_q, state_d;
  mode_e                    mode_q, mode_d, req_mode;
  logic [CW-1:0]            count_q, count_d;
  logic                     live_q, live_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            rem_q, rem_d;
  logic [CW-1:0]            posm1_q, posm1_d;
  logic [CW-1:0]            k_q, k_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     pend_q, pend_d;
  logic                     pfirst_q, pfirst_d;
  logic [AW-1:0]            paddr_q, paddr_d;
  logic [CW-1:0]            pidx_q, pidx_d;
  logic                     done_q, done_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  logic [OUT_W-1:0]         found_q, found_d;

  logic                     accept, req_err, walk_end;
  status_e                  err_st;
  logic [POS_W-1:0]         cnt_p;
  logic [CW:0]              rot_sum, rot_dst;
  logic                     div_start, div_done;
  logic [CW-1:0]            div_rem;

  assign accept   = start_i && (state_q == S_IDLE);
  assign req_mode = mode_e'(mode_i);
  assign cnt_p    = POS_W'(count_q);
  assign walk_end = (rem_q == '0) && !pend_q;
  assign rdata    = live_q ? rdata1_q : rdata0_q;

  // modulo of the rotate count by the entry count
  assign div_start = accept && !req_err && (req_mode == M_ROTATE);

  alt_divrem #(
    .CW (CW)
  ) u_divrem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rotate_count_i),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // request check
  always_comb begin
    req_err = 1'b0;
    err_st  = ST_OK;
    unique case (req_mode)
      M_INSERT: begin
        if (count_q == CW'(CAPACITY)) begin
          req_err = 1'b1;
          err_st  = ST_FULL;
        end else if (position_i == '0 || position_i > cnt_p + 1'b1) begin
          req_err = 1'b1;
          err_st  = ST_BADPOS;
        end
      end
      M_DELETE: begin
        if (count_q == '0) begin
          req_err = 1'b1;
          err_st  = ST_EMPTY;
        end else if (position_i == '0 || position_i > cnt_p) begin
          req_err = 1'b1;
          err_st  = ST_BADPOS;
        end
      end
      M_SEARCH: begin
        req_err = 1'b0;
      end
      M_ROTATE: begin
        if (count_q == '0) begin
          req_err = 1'b1;
          err_st  = ST_EMPTY;
        end
      end
      default: req_err = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !req_err) begin
          state_d = (req_mode == M_ROTATE) ? S_DIV : S_WALK;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_end) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // rotate target address, wrapped once
  always_comb begin
    rot_sum = CW1'(idx_q) + CW1'(k_q);
    if (rot_sum >= CW1'(count_q)) begin
      rot_dst = rot_sum - CW1'(count_q);
    end else begin
      rot_dst = rot_sum;
    end
  end

  // datapath, memory accesses and result
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    live_d    = live_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    posm1_d   = posm1_q;
    k_d       = k_q;
    val_d     = val_q;
    pend_d    = 1'b0;
    pfirst_d  = 1'b0;
    paddr_d   = paddr_q;
    pidx_d    = pidx_q;
    done_d    = 1'b0;
    status_d  = status_q;
    removed_d = removed_q;
    found_d   = found_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q[AW-1:0];
    wr_en     = 1'b0;
    wr_bank   = live_q;
    wr_addr   = paddr_q;
    wr_data   = rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d    = req_mode;
          val_d     = entry_value_i;
          posm1_d   = CW'(position_i - 1'b1);
          removed_d = '0;
          found_d   = '0;
          status_d  = err_st;
          done_d    = req_err;
          unique case (req_mode)
            M_INSERT: begin
              idx_d = count_q - 1'b1;
              rem_d = count_q - CW'(position_i - 1'b1);
            end
            M_DELETE: begin
              idx_d = CW'(position_i - 1'b1);
              rem_d = count_q - CW'(position_i - 1'b1);
            end
            default: begin
              idx_d = '0;
              rem_d = count_q;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) k_d = div_rem;
      end
      S_WALK: begin
        // retire the word read in the previous cycle
        if (pend_q) begin
          unique case (mode_q)
            M_INSERT: wr_en = 1'b1;
            M_DELETE: begin
              if (pfirst_q) removed_d = rdata;
              else          wr_en     = 1'b1;
            end
            M_SEARCH: begin
              if (rdata == val_q && found_q == '0) begin
                found_d = OUT_W'(pidx_q) + 1'b1;
              end
            end
            M_ROTATE: begin
              wr_en   = 1'b1;
              wr_bank = !live_q;
            end
            default: wr_en = 1'b0;
          endcase
        end
        // issue the next read
        if (rem_q != '0) begin
          rd_en    = 1'b1;
          pend_d   = 1'b1;
          pidx_d   = idx_q;
          rem_d    = rem_q - 1'b1;
          pfirst_d = (mode_q == M_DELETE) && (idx_q == posm1_q);
          idx_d    = (mode_q == M_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
          unique case (mode_q)
            M_INSERT: paddr_d = AW'(idx_q + 1'b1);
            M_DELETE: paddr_d = AW'(idx_q - 1'b1);
            M_ROTATE: paddr_d = rot_dst[AW-1:0];
            default:  paddr_d = idx_q[AW-1:0];
          endcase
        end
        // finish the request
        if (walk_end) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          unique case (mode_q)
            M_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = posm1_q[AW-1:0];
              wr_data = val_q;
              count_d = count_q + 1'b1;
            end
            M_DELETE: count_d = count_q - 1'b1;
            M_SEARCH: status_d = (found_q == '0) ? ST_NOTFOUND : ST_OK;
            M_ROTATE: live_d = !live_q;
            default:  status_d = ST_OK;
          endcase
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  // memory bank 0
  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) bank0[wr_addr] <= wr_data;
    if (rd_en) rdata0_q <= bank0[rd_addr];
  end

  // memory bank 1
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_bank) bank1[wr_addr] <= wr_data;
    if (rd_en) rdata1_q <= bank1[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      live_q  <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      rem_q   <= '0;
      mode_q  <= M_INSERT;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      live_q  <= live_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      rem_q   <= rem_d;
      mode_q  <= mode_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    posm1_q   <= posm1_d;
    k_q       <= k_d;
    val_q     <= val_d;
    pfirst_q  <= pfirst_d;
    paddr_q   <= paddr_d;
    pidx_q    <= pidx_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign removed_value_o  = removed_q;
  assign found_position_o = found_q;
  assign item_count_o     = OUT_W'(count_q);

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // no read left in flight once idle
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_q)
    else $error("pending read while idle");

  // a successful insert grows the list by one word
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == ST_OK && mode_q == M_INSERT |->
      count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow count");

  // a found position lies inside the list
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> found_q <= OUT_W'(count_q))
    else $error("found position beyond count");

  // a result follows only a walk or a rejected request
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(state_q == S_WALK) || $past(accept && req_err))
    else $error("result strobe without a request");

endmodule
